// ----- hdl/internet_checksum_pseudo_header_defines.svh -----
// Assertion macros used by the checksum block's accumulator, icph_acc.
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ICPH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icph assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ICPH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icph assertion failed");

`endif

// ----- hdl/icph_pkg.sv -----
// Shared widths, register codes, types and the ones'-complement fold for the checksum block.
`default_nettype none

package icph_pkg;

    localparam int DataW    = 8;
    localparam int WordW    = 16;
    localparam int AddrW    = 32;
    localparam int ProtoW   = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int WideW    = WordW + 3;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SRC_ADDR  = 3'd0,
        CFG_DST_ADDR  = 3'd1,
        CFG_PROTOCOL  = 3'd2,
        CFG_PSEUDO_EN = 3'd3,
        CFG_INIT_SUM  = 3'd4
    } cfg_index_t;

    // Settings that the datapath needs from the configuration registers.
    typedef struct packed {
        logic             pseudo_en;
        logic [WordW-1:0] base_sum;
    } sum_cfg_t;

    // Folds a sum of up to eight 16-bit words back to 16 bits with end-around carry.
    // The result is zero only when the wide sum is zero, as with a chain of single adds.
    function automatic logic [WordW-1:0] oc_fold(input logic [WideW-1:0] s);
        logic [WordW:0] t;
        t = {1'b0, s[WordW-1:0]} + {{(WordW-2){1'b0}}, s[WideW-1:WordW]};
        return t[WordW-1:0] + {{(WordW-1){1'b0}}, t[WordW]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/icph_cfg.sv -----
// Configuration registers and the pre-summed pseudo-header constant.
`default_nettype none

module icph_cfg
    import icph_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output sum_cfg_t                 sum_cfg
);

    logic [AddrW-1:0]  src_reg;
    logic [AddrW-1:0]  dst_reg;
    logic [ProtoW-1:0] proto_reg;
    logic              pen_reg;
    logic [WordW-1:0]  init_reg;
    sum_cfg_t          sum_cfg_reg;
    sum_cfg_t          sum_cfg_next;
    logic [WideW-1:0]  hdr_wide;

    // Writes are always taken at once.
    assign cfg_ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg   <= '0;
            dst_reg   <= '0;
            proto_reg <= '0;
            pen_reg   <= 1'b1;
            init_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SRC_ADDR:  src_reg   <= cfg_data[AddrW-1:0];
                CFG_DST_ADDR:  dst_reg   <= cfg_data[AddrW-1:0];
                CFG_PROTOCOL:  proto_reg <= cfg_data[ProtoW-1:0];
                CFG_PSEUDO_EN: pen_reg   <= cfg_data[0];
                CFG_INIT_SUM:  init_reg  <= cfg_data[WordW-1:0];
                default:       ;
            endcase
        end
    end

    // Address halves and protocol word summed once, so the per-byte path adds a single word.
    always_comb
    begin
        hdr_wide = {3'b000, src_reg[AddrW-1:WordW]} + {3'b000, src_reg[WordW-1:0]}
                 + {3'b000, dst_reg[AddrW-1:WordW]} + {3'b000, dst_reg[WordW-1:0]}
                 + {{(WideW-ProtoW){1'b0}}, proto_reg};
        sum_cfg_next.pseudo_en = pen_reg;
        sum_cfg_next.base_sum  = pen_reg ? oc_fold(hdr_wide) : init_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_cfg_reg.pseudo_en <= 1'b1;
            sum_cfg_reg.base_sum  <= '0;
        end
        else
        begin
            sum_cfg_reg <= sum_cfg_next;
        end
    end

    assign sum_cfg = sum_cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/icph_acc.sv -----
// Byte input register, pairing and running-sum state, and the result register.
`default_nettype none

module icph_acc
    import icph_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DataW-1:0]   s_tdata,
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [2*WordW-1:0]      m_tdata,
    input  wire sum_cfg_t           sum_cfg
);

    `include "internet_checksum_pseudo_header_defines.svh"

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [DataW-1:0] byte_reg;
    logic             last_reg;
    logic [WordW-1:0] running_reg;
    logic [WordW-1:0] running_next;
    logic [DataW-1:0] held_reg;
    logic [DataW-1:0] held_next;
    logic             odd_reg;
    logic             odd_next;
    logic [WordW-1:0] cnt_reg;
    logic [WordW-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WordW-1:0] csum_reg;
    logic [WordW-1:0] len_reg;

    logic             adv;
    logic [WordW-1:0] word;
    logic [WordW-1:0] cnt_inc;
    logic [WordW-1:0] len_term;
    logic [WordW-1:0] pair_sum;
    logic [WordW-1:0] total;

    // The held byte moves on unless it closes a packet while an unread result is waiting.
    assign adv      = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // Word formed by this byte: a closed pair, or a lone final byte padded low.
    assign word     = odd_reg ? {held_reg, byte_reg} : {byte_reg, {DataW{1'b0}}};
    assign cnt_inc  = (cnt_reg == {WordW{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign len_term = sum_cfg.pseudo_en ? cnt_inc : '0;
    assign pair_sum = oc_fold({3'b000, running_reg} + {3'b000, word});
    assign total    = oc_fold({3'b000, running_reg} + {3'b000, word}
                            + {3'b000, sum_cfg.base_sum} + {3'b000, len_term});

    // Input register control.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    // Packet state: pair bytes, add closed words, clear after the final byte.
    always_comb
    begin
        running_next = running_reg;
        held_next    = held_reg;
        odd_next     = odd_reg;
        cnt_next     = cnt_reg;
        if (adv)
        begin
            if (last_reg)
            begin
                running_next = '0;
                held_next    = '0;
                odd_next     = 1'b0;
                cnt_next     = '0;
            end
            else if (odd_reg)
            begin
                running_next = pair_sum;
                held_next    = '0;
                odd_next     = 1'b0;
                cnt_next     = cnt_inc;
            end
            else
            begin
                held_next    = byte_reg;
                odd_next     = 1'b1;
                cnt_next     = cnt_inc;
            end
        end
    end

    // Result register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            running_reg   <= '0;
            held_reg      <= '0;
            odd_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            running_reg   <= running_next;
            held_reg      <= held_next;
            odd_reg       <= odd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (adv && last_reg)
        begin
            csum_reg <= ~total;
            len_reg  <= cnt_inc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {len_reg, csum_reg};

    // A result appears only when a final byte has just left the input register.
    `ICPH_ASSERT_IMPL(a_result_from_last, $rose(out_valid_reg), $past(adv && last_reg))
    // The packet state is clear after a final byte is summed.
    `ICPH_ASSERT_NEXT(a_clear_after_last, adv && last_reg,
                      !odd_reg && cnt_reg == '0 && running_reg == '0)
    // A byte inside a packet always leaves a nonzero count behind.
    `ICPH_ASSERT_NEXT(a_count_moves, adv && !last_reg, cnt_reg != '0)
    // A held high byte means an odd number of bytes so far.
    `ICPH_ASSERT_IMPL(a_phase_matches_count, odd_reg && cnt_reg != {WordW{1'b1}}, cnt_reg[0])

endmodule

`default_nettype wire

// ----- hdl/internet_checksum_pseudo_header.sv -----
// Top level of the streaming Internet checksum with optional TCP/UDP pseudo-header.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = last
//  m_*      | out       | m_tvalid/m_tready  | m_tdata = checksum_value, byte_length
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte is accepted every cycle unless a final byte waits on an unread result; a final
// byte's result is loaded into the output register as that byte leaves the input register.
// The per-byte path is one four-word add with end-around carry folds.
// The input keeps accepting while a result waits, until a further final byte finds the
// result register still full. Reset clears all packet state; no clearing pass is needed.
`default_nettype none

module internet_checksum_pseudo_header
    import icph_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [DataW-1:0]    s_tdata,   // [7:0] data_byte
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [2*WordW-1:0]       m_tdata,   // [15:0] checksum_value, [31:16] byte_length
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    sum_cfg_t sum_cfg;

    // Configuration registers.
    icph_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sum_cfg   (sum_cfg)
    );

    // Byte datapath and result register.
    icph_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .sum_cfg  (sum_cfg)
    );

endmodule

`default_nettype wire

// ----- dv/internet_checksum_pseudo_header_test.sv -----
// Self-checking testbench for the streaming Internet checksum block with pseudo-header.
module internet_checksum_pseudo_header_test;
    import icph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IdlePct      = 13;
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned TailCycles   = 10;
    localparam int unsigned RandomBytes  = 600;
    localparam int unsigned MaxReports   = 10;
    localparam int unsigned CycleLimit   = 1000000;

    localparam logic [WordW-1:0]   CountMax   = 16'hffff;
    localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

    // Kinds of entry in the stimulus queue.
    typedef enum logic [1:0] {
        REQ_BYTE,
        REQ_CFG,
        REQ_SETTLE
    } req_kind_t;

    typedef struct packed {
        req_kind_t            kind;
        logic [DataW-1:0]     data;
        logic                 last;
        logic                 calm;
        logic [CfgIdxW-1:0]   index;
        logic [CfgDataW-1:0]  value;
    } stim_req_t;

    typedef struct packed {
        logic [WordW-1:0] checksum;
        logic [WordW-1:0] length;
    } csum_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [DataW-1:0]    s_tdata   = '0;   // [7:0] data_byte
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [2*WordW-1:0]  m_tdata;          // [15:0] checksum_value, [31:16] byte_length
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;

    stim_req_t    pending_reqs[$];
    csum_result_t expected_sums[$];

    // Shadow copy of the configuration registers, at their reset values.
    logic [AddrW-1:0]  reg_src_addr  = '0;
    logic [AddrW-1:0]  reg_dst_addr  = '0;
    logic [ProtoW-1:0] reg_protocol  = '0;
    logic              reg_pseudo_en = 1'b1;
    logic [WordW-1:0]  reg_init_sum  = '0;

    // Shadow copy of the packet state.
    logic [WordW-1:0] pkt_sum   = '0;
    logic [DataW-1:0] pkt_high  = '0;
    logic             pkt_odd   = 1'b0;
    logic [WordW-1:0] pkt_count = '0;

    logic        calm_now       = 1'b0;
    int unsigned error_count    = 0;
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned packets_seen   = 0;
    int unsigned results_seen   = 0;
    int unsigned cfg_writes     = 0;
    int unsigned cycle_count    = 0;

    internet_checksum_pseudo_header u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Ones'-complement add of two words with end-around carry.
    function automatic logic [WordW-1:0] ones_add(input logic [WordW-1:0] a,
                                                  input logic [WordW-1:0] b);
        logic [WordW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
    endfunction

    // Applies an accepted register write to the shadow registers.
    function automatic void apply_setting(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] val);
        case (idx)
            CFG_SRC_ADDR:  reg_src_addr  = val[AddrW-1:0];
            CFG_DST_ADDR:  reg_dst_addr  = val[AddrW-1:0];
            CFG_PROTOCOL:  reg_protocol  = val[ProtoW-1:0];
            CFG_PSEUDO_EN: reg_pseudo_en = val[0];
            CFG_INIT_SUM:  reg_init_sum  = val[WordW-1:0];
            default:       ;
        endcase
    endfunction

    // Folds one accepted byte into the packet sum; a final byte yields the expected checksum.
    function automatic void accumulate_byte(input logic [DataW-1:0] d, input logic is_last);
        logic [WordW-1:0] total;
        csum_result_t     res;
        if (pkt_count != CountMax)
            pkt_count = pkt_count + 1'b1;
        if (pkt_odd)
        begin
            pkt_sum  = ones_add(pkt_sum, {pkt_high, d});
            pkt_odd  = 1'b0;
            pkt_high = '0;
        end
        else if (is_last)
            pkt_sum = ones_add(pkt_sum, {d, 8'h00});
        else
        begin
            pkt_high = d;
            pkt_odd  = 1'b1;
        end
        if (is_last)
        begin
            total = pkt_sum;
            if (reg_pseudo_en)
            begin
                total = ones_add(total, reg_src_addr[31:16]);
                total = ones_add(total, reg_src_addr[15:0]);
                total = ones_add(total, reg_dst_addr[31:16]);
                total = ones_add(total, reg_dst_addr[15:0]);
                total = ones_add(total, {8'h00, reg_protocol});
                total = ones_add(total, pkt_count);
            end
            else
                total = ones_add(total, reg_init_sum);
            res.checksum = ~total;
            res.length   = pkt_count;
            expected_sums.push_back(res);
            packets_seen = packets_seen + 1;
            pkt_sum   = '0;
            pkt_high  = '0;
            pkt_odd   = 1'b0;
            pkt_count = '0;
        end
    endfunction

    // Counts a failure and reports the first few of them.
    function automatic void flag_error(input string msg);
        error_count = error_count + 1;
        if (error_count <= MaxReports)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Stimulus queue helpers.
    function automatic void add_byte(input logic [DataW-1:0] d, input logic is_last,
                                     input logic calm);
        stim_req_t r;
        r = '0;
        r.kind = REQ_BYTE;
        r.data = d;
        r.last = is_last;
        r.calm = calm;
        pending_reqs.push_back(r);
        bytes_queued = bytes_queued + 1;
    endfunction

    // A register write goes in only once the block has gone quiet.
    function automatic void add_write(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] val);
        stim_req_t r;
        r = '0;
        r.kind = REQ_SETTLE;
        pending_reqs.push_back(r);
        r.kind  = REQ_CFG;
        r.index = idx;
        r.value = val;
        pending_reqs.push_back(r);
    endfunction

    function automatic void add_settings(input logic [AddrW-1:0] src,
                                         input logic [AddrW-1:0] dst,
                                         input logic [ProtoW-1:0] proto,
                                         input logic pseudo_en,
                                         input logic [WordW-1:0] init);
        add_write(CFG_SRC_ADDR, src);
        add_write(CFG_DST_ADDR, dst);
        add_write(CFG_PROTOCOL, {24'h0, proto});
        add_write(CFG_PSEUDO_EN, {31'h0, pseudo_en});
        add_write(CFG_INIT_SUM, {16'h0, init});
    endfunction

    // Packet of random bytes, leaning towards the extreme values.
    function automatic void add_packet(input int unsigned len, input logic calm);
        logic [DataW-1:0] d;
        for (int unsigned i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0:       d = 8'hff;
                1:       d = 8'h00;
                default: d = 8'($urandom());
            endcase
            add_byte(d, i == len - 1, calm);
        end
    endfunction

    // Driver: presents queued bytes and register writes, and predicts on each acceptance.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic        s_hold;
        logic        cfg_hold;
        logic        s_valid_nxt;
        logic        cfg_valid_nxt;
        int unsigned settle_count;
        stim_req_t   head;
        if (!rst_n)
        begin
            s_tvalid     <= 1'b0;
            s_tdata      <= '0;
            s_tlast      <= 1'b0;
            cfg_valid    <= 1'b0;
            cfg_index    <= '0;
            cfg_data     <= '0;
            settle_count = 0;
        end
        else
        begin
            s_hold   = s_tvalid && !s_tready;
            cfg_hold = cfg_valid && !cfg_ready;
            if (s_tvalid && s_tready)
            begin
                accumulate_byte(s_tdata, s_tlast);
                bytes_accepted = bytes_accepted + 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_setting(cfg_index, cfg_data);
                cfg_writes = cfg_writes + 1;
            end
            s_valid_nxt   = s_hold;
            cfg_valid_nxt = cfg_hold;

            // Start the next request once nothing is outstanding.
            if (!s_hold && !cfg_hold && pending_reqs.size() != 0)
            begin
                head = pending_reqs[0];
                case (head.kind)
                    REQ_BYTE:
                    begin
                        calm_now <= head.calm;
                        if (head.calm || $urandom_range(0, 99) >= IdlePct)
                        begin
                            s_valid_nxt = 1'b1;
                            s_tdata     <= head.data;
                            s_tlast     <= head.last;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    REQ_CFG:
                    begin
                        cfg_valid_nxt = 1'b1;
                        cfg_index     <= head.index;
                        cfg_data      <= head.value;
                        void'(pending_reqs.pop_front());
                    end
                    default:
                    begin
                        // Hold off until every result is in and the pipeline has emptied.
                        if (expected_sums.size() == 0 && !s_tvalid)
                        begin
                            settle_count = settle_count + 1;
                            if (settle_count >= SettleCycles)
                            begin
                                settle_count = 0;
                                void'(pending_reqs.pop_front());
                            end
                        end
                        else
                            settle_count = 0;
                    end
                endcase
            end
            s_tvalid  <= s_valid_nxt;
            cfg_valid <= cfg_valid_nxt;
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        csum_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen = results_seen + 1;
                if (expected_sums.size() == 0)
                    flag_error($sformatf("unexpected result checksum %h length %0d",
                                         m_tdata[15:0], m_tdata[31:16]));
                else
                begin
                    want = expected_sums.pop_front();
                    if (m_tdata[15:0] !== want.checksum)
                        flag_error($sformatf("checksum expected %h actual %h",
                                             want.checksum, m_tdata[15:0]));
                    if (m_tdata[31:16] !== want.length)
                        flag_error($sformatf("byte length expected %0d actual %0d",
                                             want.length, m_tdata[31:16]));
                end
            end
            m_tready <= calm_now || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_sums.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Builds the stimulus, releases reset and waits for the run to complete.
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned style;
        int unsigned len;

        // Directed: reset settings, pseudo-header with zero addresses.
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hff, 1'b0, 1'b0);
        add_byte(8'hff, 1'b1, 1'b0);
        // Plain checksum from zero: an all-zero sum and a sum of all ones.
        add_settings('0, '0, '0, 1'b0, '0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hff, 1'b0, 1'b0);
        add_byte(8'hff, 1'b1, 1'b0);
        // Largest initial sum with an odd single byte.
        add_write(CFG_INIT_SUM, 32'h0000_ffff);
        add_byte(8'hff, 1'b1, 1'b0);
        // Pseudo-header with every address and protocol bit set.
        add_settings('1, '1, '1, 1'b1, 16'h1234);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'hfe, 1'b1, 1'b0);
        // Typical UDP settings.
        add_settings(32'hc0a8_0001, 32'h0a00_0002, 8'd17, 1'b1, 16'h0);
        add_byte(8'h12, 1'b0, 1'b0);
        add_byte(8'h34, 1'b0, 1'b0);
        add_byte(8'h56, 1'b0, 1'b0);
        add_byte(8'h78, 1'b1, 1'b0);
        // Writes to unused indexes must leave every register alone.
        add_write(CfgSpareLo, '1);
        add_write(CfgSpareHi, '1);
        add_byte(8'ha5, 1'b0, 1'b0);
        add_byte(8'h5a, 1'b1, 1'b0);

        // Random packets under changing settings; one phase runs without idling.
        phase = 0;
        bytes_queued = 0;
        while (bytes_queued < RandomBytes)
        begin
            style = $urandom_range(0, 3);
            case (style)
                0:       add_settings('0, '0, '0, 1'($urandom()), '0);
                1:       add_settings('1, '1, '1, 1'($urandom()), '1);
                default: add_settings($urandom(), $urandom(), 8'($urandom()),
                                      1'($urandom()), 16'($urandom()));
            endcase
            if ($urandom_range(0, 3) == 0)
                add_write(CfgSpareLo + CfgIdxW'($urandom_range(0, 2)), $urandom());
            for (int k = 0; k < 6; k++)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 64)
                                                  : $urandom_range(1, 20);
                add_packet(len, phase == 2);
            end
            phase = phase + 1;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || cfg_valid || expected_sums.size() != 0)
            @(negedge clk);
        repeat (TailCycles) @(negedge clk);

        if (expected_sums.size() != 0)
            flag_error($sformatf("%0d predicted results never arrived", expected_sums.size()));

        $display("Run covered %0d payload bytes in %0d packets, %0d results checked,",
                 bytes_accepted, packets_seen, results_seen);
        $display("with %0d register writes across both the pseudo-header and plain modes.",
                 cfg_writes);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/icph_pkg.sv
hdl/icph_cfg.sv
hdl/icph_acc.sv
hdl/internet_checksum_pseudo_header.sv
dv/internet_checksum_pseudo_header_test.sv
